>>> src/dbb_pkg.sv
// Shared constants and types for the dilated 5x5 binomial blur.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps

package dbb_pkg;

  localparam int MaxWidthDefault  = 1024;
  localparam int PixelBitsDefault = 16;

  localparam int CfgWidthBits  = 11;
  localparam int CfgHeightBits = 13;
  localparam int CfgDataBits   = 13;
  localparam int CfgIndexBits  = 2;

  localparam logic [CfgIndexBits-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIndexBits-1:0] RegImageHeight = 2'd1;

  localparam logic [CfgWidthBits-1:0]  WidthReset  = 11'd1024;
  localparam logic [CfgHeightBits-1:0] HeightReset = 13'd1024;

  localparam int Taps      = 5;
  localparam int WinCols   = 9;
  localparam int StoreRows = 8;
  localparam int DenBits   = 9;
  localparam int WsumBits  = 5;

  localparam logic [2:0] TapWeight [Taps] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

  typedef struct packed {
    logic [Taps-1:0] xm;
    logic [Taps-1:0] ym;
    logic            last;
  } dbb_meta_t;

  function automatic logic [WsumBits-1:0] weight_sum(input logic [Taps-1:0] m);
    logic [WsumBits-1:0] s;
    s = '0;
    for (int t = 0; t < Taps; t++) begin
      if (m[t]) s = s + WsumBits'(TapWeight[t]);
    end
    return s;
  endfunction

endpackage

>>> src/dilated_binomial_blur_5x5.sv
// Top level of the dilated 5x5 binomial blur: config registers, pipeline, output register.
// Depends on dbb_pkg, dbb_window, dbb_sum, dbb_div.
//
// Usage:
//   Pixels enter in raster order on in_valid_i / in_stall_o with pixel_value_i and
//   is_pad_i. Each frame is followed by 4*W+4 pad items, which flush the last outputs.
//   Results leave on out_valid_o / out_stall_i; frame_last_o marks the last pixel.
//   Item n of a frame (counting from 0) yields the output for raster position
//   n - (4*W+4); earlier items yield none.
//   A result passes through one store read, one window stage, two sum stages, one
//   divider setup stage, one stage per quotient bit, and the output register.
//   Throughput: one item per cycle while in_stall_o is low.
//   The output register holds its result while out_stall_i is high; input transfers
//   continue as long as the stage ahead of it is empty, otherwise in_stall_o rises
//   and the whole pipeline holds.
//   Configuration (index 0 image_width, 1 image_height) is written on
//   cfg_valid_i / cfg_ready_o; the user must do so only between frames, which the
//   block does not enforce. Reset sets both to 1024, empties the pipeline and
//   returns the frame counters to the first pixel.
`timescale 1ns / 1ps

module dilated_binomial_blur_5x5 #(
  parameter int MAX_WIDTH  = dbb_pkg::MaxWidthDefault,
  parameter int PIXEL_BITS = dbb_pkg::PixelBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [PIXEL_BITS-1:0]             pixel_value_i,
  input  logic                              is_pad_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [PIXEL_BITS-1:0]             smoothed_value_o,
  output logic                              frame_last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dbb_pkg::CfgIndexBits-1:0]  cfg_index_i,
  input  logic [dbb_pkg::CfgDataBits-1:0]   cfg_data_i
);

  localparam int CW = dbb_pkg::CfgWidthBits;
  localparam int HW = dbb_pkg::CfgHeightBits;

  logic [CW-1:0] iw_q, w_eff;
  logic [HW-1:0] ih_q, h_eff;

  logic en, out_free;

  logic                            win_v;
  logic [4:0][4:0][PIXEL_BITS-1:0] taps;
  dbb_pkg::dbb_meta_t              meta;

  logic                            sum_v, sum_last;
  logic [PIXEL_BITS+7:0]           vsum;
  logic [dbb_pkg::DenBits-1:0]     den;

  logic                            pre_v, pre_last;
  logic [PIXEL_BITS-1:0]           pre_quo;

  logic                            out_v_q, out_last_q;
  logic [PIXEL_BITS-1:0]           out_val_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q <= dbb_pkg::WidthReset;
      ih_q <= dbb_pkg::HeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dbb_pkg::RegImageWidth:  iw_q <= cfg_data_i[CW-1:0];
        dbb_pkg::RegImageHeight: ih_q <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (iw_q == '0) begin
      w_eff = CW'(1);
    end else if (32'(iw_q) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = iw_q;
    end
    h_eff = (ih_q == '0) ? HW'(1) : ih_q;
  end

  assign out_free   = !out_v_q || !out_stall_i;
  assign en         = out_free || !pre_v;
  assign in_stall_o = !en;

  dbb_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .pixel_i     (pixel_value_i),
    .is_pad_i    (is_pad_i),
    .width_i     (w_eff),
    .height_i    (h_eff),
    .out_valid_o (win_v),
    .taps_o      (taps),
    .meta_o      (meta)
  );

  dbb_sum #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (win_v),
    .taps_i      (taps),
    .meta_i      (meta),
    .out_valid_o (sum_v),
    .vsum_o      (vsum),
    .den_o       (den),
    .last_o      (sum_last)
  );

  dbb_div #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (sum_v),
    .vsum_i      (vsum),
    .den_i       (den),
    .last_i      (sum_last),
    .out_valid_o (pre_v),
    .quo_o       (pre_quo),
    .last_o      (pre_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= pre_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_val_q  <= pre_quo;
      out_last_q <= pre_last;
    end
  end

  assign out_valid_o      = out_v_q;
  assign smoothed_value_o = out_val_q;
  assign frame_last_o     = out_last_q;

endmodule

>>> src/dbb_window.sv
// Input stage: frame counters, eight-row column store, 9-column tap window.
// Depends on dbb_pkg.
`timescale 1ns / 1ps

module dbb_window #(
  parameter int MAX_WIDTH  = dbb_pkg::MaxWidthDefault,
  parameter int PIXEL_BITS = dbb_pkg::PixelBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   in_valid_i,
  input  logic [PIXEL_BITS-1:0]                  pixel_i,
  input  logic                                   is_pad_i,
  input  logic [dbb_pkg::CfgWidthBits-1:0]       width_i,
  input  logic [dbb_pkg::CfgHeightBits-1:0]      height_i,
  output logic                                   out_valid_o,
  output logic [4:0][4:0][PIXEL_BITS-1:0]        taps_o,
  output dbb_pkg::dbb_meta_t                     meta_o
);

  localparam int CW = dbb_pkg::CfgWidthBits;
  localparam int HW = dbb_pkg::CfgHeightBits;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(4 * MAX_WIDTH + 5);
  localparam int NR = dbb_pkg::StoreRows;
  localparam int NC = dbb_pkg::WinCols;

  typedef logic [NR-1:0][PIXEL_BITS-1:0] word_t;
  typedef logic [4:0][PIXEL_BITS-1:0]    colv_t;

  word_t mem [MAX_WIDTH];

  logic [CW-1:0] c_q, ci_q;
  logic [HW:0]   r_q;
  logic [HW-1:0] cj_q;
  logic [LW-1:0] cnt_q, lag;

  logic               acc, out_d, last_d, wrap_c, wrap_i;
  logic [AW-1:0]      addr;
  logic [PIXEL_BITS-1:0] pix_in;
  dbb_pkg::dbb_meta_t meta_d;

  logic               s0_v_q, s0_out_q, fwd_q;
  logic [AW-1:0]      s0_addr_q;
  logic [PIXEL_BITS-1:0] s0_pix_q;
  dbb_pkg::dbb_meta_t s0_meta_q;
  word_t              rd_q, fwd_word_q, rd_eff, wr_word;
  colv_t              col_vec;

  colv_t              win_q [NC];
  logic               s1_v_q;
  dbb_pkg::dbb_meta_t s1_meta_q;

  assign acc  = in_valid_i && en_i;
  assign addr = AW'(c_q);

  always_comb begin
    lag    = (LW'(width_i) << 2) + LW'(4);
    out_d  = cnt_q >= lag;
    last_d = out_d && (({1'b0, cj_q} + 1'b1 > {1'b0, height_i}) ||
             (({1'b0, cj_q} + 1'b1 == {1'b0, height_i}) &&
              ({1'b0, ci_q} + 1'b1 >= {1'b0, width_i})));
    wrap_c = {1'b0, c_q} + 1'b1 >= {1'b0, width_i};
    wrap_i = {1'b0, ci_q} + 1'b1 >= {1'b0, width_i};
    pix_in = (is_pad_i && (r_q >= (HW+1)'(height_i))) ? '0 : pixel_i;
    meta_d.last = last_d;
    for (int d = 0; d < 5; d++) begin
      meta_d.xm[d] = (({1'b0, ci_q} + (CW+1)'(2 * d)) >= (CW+1)'(4)) &&
                     (({1'b0, ci_q} + (CW+1)'(2 * d)) < ({1'b0, width_i} + (CW+1)'(4)));
      meta_d.ym[d] = (({1'b0, cj_q} + (HW+1)'(2 * d)) >= (HW+1)'(4)) &&
                     (({1'b0, cj_q} + (HW+1)'(2 * d)) < ({1'b0, height_i} + (HW+1)'(4)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q   <= '0;
      r_q   <= '0;
      ci_q  <= '0;
      cj_q  <= '0;
      cnt_q <= '0;
    end else if (acc) begin
      if (last_d) begin
        c_q   <= '0;
        r_q   <= '0;
        ci_q  <= '0;
        cj_q  <= '0;
        cnt_q <= '0;
      end else begin
        if (wrap_c) begin
          c_q <= '0;
          r_q <= r_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
        if (!out_d) begin
          cnt_q <= cnt_q + 1'b1;
        end else if (wrap_i) begin
          ci_q <= '0;
          cj_q <= cj_q + 1'b1;
        end else begin
          ci_q <= ci_q + 1'b1;
        end
      end
    end
  end

  // store word k holds row (current - 1 - k) at this column
  always_comb begin
    rd_eff     = fwd_q ? fwd_word_q : rd_q;
    wr_word[0] = s0_pix_q;
    for (int k = 1; k < NR; k++) wr_word[k] = rd_eff[k-1];
    col_vec[0] = rd_eff[7];
    col_vec[1] = rd_eff[5];
    col_vec[2] = rd_eff[3];
    col_vec[3] = rd_eff[1];
    col_vec[4] = s0_pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (s0_v_q && en_i) mem[s0_addr_q] <= wr_word;
    if (acc) rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else if (en_i) begin
      s0_v_q <= in_valid_i;
      fwd_q  <= in_valid_i && s0_v_q && (s0_addr_q == addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s0_pix_q   <= pix_in;
      s0_addr_q  <= addr;
      s0_out_q   <= out_d;
      s0_meta_q  <= meta_d;
      fwd_word_q <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= s0_v_q && s0_out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s1_meta_q <= s0_meta_q;
    if (en_i && s0_v_q) begin
      win_q[0] <= col_vec;
      for (int m = 1; m < NC; m++) win_q[m] <= win_q[m-1];
    end
  end

  always_comb begin
    for (int dy = 0; dy < 5; dy++) begin
      for (int dx = 0; dx < 5; dx++) taps_o[dy][dx] = win_q[8 - 2 * dx][dy];
    end
  end

  assign out_valid_o = s1_v_q;
  assign meta_o      = s1_meta_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_d |=> (cnt_q == '0) && (ci_q == '0) && (c_q == '0))
    else $error("counters not cleared after frame end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s0_v_q)
    else $error("store forward without a stage-0 item");

endmodule

>>> src/dbb_sum.sv
// Weighted tap sums: masked row sums, then column sum and weight total.
// Depends on dbb_pkg.
`timescale 1ns / 1ps

module dbb_sum #(
  parameter int PIXEL_BITS = dbb_pkg::PixelBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               in_valid_i,
  input  logic [4:0][4:0][PIXEL_BITS-1:0]    taps_i,
  input  dbb_pkg::dbb_meta_t                 meta_i,
  output logic                               out_valid_o,
  output logic [PIXEL_BITS+7:0]              vsum_o,
  output logic [dbb_pkg::DenBits-1:0]        den_o,
  output logic                               last_o
);

  localparam int RW = PIXEL_BITS + 4;
  localparam int VW = PIXEL_BITS + 8;
  localparam int DW = dbb_pkg::DenBits;
  localparam int SW = dbb_pkg::WsumBits;

  logic [4:0][RW-1:0] rs_d, rs_q;
  logic [SW-1:0]      wsx_q;
  logic [4:0]         ym_q;
  logic               lasta_q, va_q;

  logic [VW-1:0]      vs_d, vs_q;
  logic [DW-1:0]      den_d, den_q;
  logic               lastb_q, vb_q;

  always_comb begin
    for (int dy = 0; dy < 5; dy++) begin
      rs_d[dy] = '0;
      for (int dx = 0; dx < 5; dx++) begin
        if (meta_i.xm[dx]) begin
          rs_d[dy] = rs_d[dy] + RW'(taps_i[dy][dx]) * RW'(dbb_pkg::TapWeight[dx]);
        end
      end
    end
  end

  always_comb begin
    vs_d = '0;
    for (int dy = 0; dy < 5; dy++) begin
      if (ym_q[dy]) vs_d = vs_d + VW'(rs_q[dy]) * VW'(dbb_pkg::TapWeight[dy]);
    end
    den_d = DW'(wsx_q) * DW'(dbb_pkg::weight_sum(ym_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rs_q    <= rs_d;
      wsx_q   <= dbb_pkg::weight_sum(meta_i.xm);
      ym_q    <= meta_i.ym;
      lasta_q <= meta_i.last;
      vs_q    <= vs_d;
      den_q   <= den_d;
      lastb_q <= lasta_q;
    end
  end

  assign out_valid_o = vb_q;
  assign vsum_o      = vs_q;
  assign den_o       = den_q;
  assign last_o      = lastb_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> den_q <= DW'(256))
    else $error("weight total above full window");

endmodule

>>> src/dbb_div.sv
// Rounded division of the tap sum by the weight total, one quotient bit per stage.
// Depends on dbb_pkg.
`timescale 1ns / 1ps

module dbb_div #(
  parameter int PIXEL_BITS = dbb_pkg::PixelBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic [PIXEL_BITS+7:0]         vsum_i,
  input  logic [dbb_pkg::DenBits-1:0]   den_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  output logic [PIXEL_BITS-1:0]         quo_o,
  output logic                          last_o
);

  localparam int P  = PIXEL_BITS;
  localparam int NW = PIXEL_BITS + 9;
  localparam int DW = dbb_pkg::DenBits;

  logic [NW-1:0] rem_q [P+1];
  logic [P-1:0]  q_q   [P+1];
  logic [DW-1:0] den_q [P+1];
  logic [P:0]    v_q, last_q, zero_q;

  logic [NW-1:0] rem_n [P];
  logic [P-1:0]  q_n   [P];
  logic [NW-1:0] sh;

  always_comb begin
    for (int k = 0; k < P; k++) begin
      sh = NW'(den_q[k]) << (P - 1 - k);
      if (rem_q[k] >= sh) begin
        rem_n[k] = rem_q[k] - sh;
        q_n[k]   = q_q[k] | (P'(1) << (P - 1 - k));
      end else begin
        rem_n[k] = rem_q[k];
        q_n[k]   = q_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[P-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= NW'(vsum_i) + NW'(den_i >> 1);
      q_q[0]    <= '0;
      den_q[0]  <= den_i;
      last_q[0] <= last_i;
      zero_q[0] <= den_i == '0;
      for (int k = 0; k < P; k++) begin
        rem_q[k+1]  <= rem_n[k];
        q_q[k+1]    <= q_n[k];
        den_q[k+1]  <= den_q[k];
        last_q[k+1] <= last_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  assign out_valid_o = v_q[P];
  assign quo_o       = zero_q[P] ? '0 : q_q[P];
  assign last_o      = last_q[P];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[P] |-> zero_q[P] || (rem_q[P] < NW'(den_q[P])))
    else $error("division remainder not below divisor");

endmodule
